@@ rtl/core/tlpd_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpd_pkg
// Shared types, codes and helpers of the two-line pulse-dial call controller.
// ----------------------------------------------------------------------------
package tlpd_pkg;

	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int EXT_W      = 7;
	localparam int PULSE_W    = 5;
	localparam int DIAL_W     = 7;
	localparam int DIGITS_W   = 2;
	localparam int STATE_W    = 3;
	localparam int TONE_W     = 2;
	localparam int DIGIT_W    = 4;
	localparam int CMD_W      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ABORT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTERDIG = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXT1     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXT2     = 3'd5;

	localparam logic [STATE_W-1:0] ST_IDLE      = 3'd0;
	localparam logic [STATE_W-1:0] ST_DIALTONE  = 3'd1;
	localparam logic [STATE_W-1:0] ST_PULSING   = 3'd2;
	localparam logic [STATE_W-1:0] ST_RINGOUT   = 3'd3;
	localparam logic [STATE_W-1:0] ST_RINGIN    = 3'd4;
	localparam logic [STATE_W-1:0] ST_TALKING   = 3'd5;
	localparam logic [STATE_W-1:0] ST_BUSY      = 3'd6;

	localparam logic [TONE_W-1:0] TONE_SILENT   = 2'd0;
	localparam logic [TONE_W-1:0] TONE_DIAL     = 2'd1;
	localparam logic [TONE_W-1:0] TONE_RINGBACK = 2'd2;
	localparam logic [TONE_W-1:0] TONE_BUSY     = 2'd3;

	localparam logic [DIGIT_W-1:0] NO_DIGIT  = 4'd10;
	localparam logic [PULSE_W-1:0] PULSE_MAX = 5'd31;

	localparam logic [CFG_W-1:0] RST_DEBOUNCE = 16'd15;
	localparam logic [CFG_W-1:0] RST_ABORT    = 16'd300;
	localparam logic [CFG_W-1:0] RST_GAP      = 16'd600;
	localparam logic [CFG_W-1:0] RST_INTERDIG = 16'd4000;
	localparam logic [EXT_W-1:0] RST_EXT1     = 7'd11;
	localparam logic [EXT_W-1:0] RST_EXT2     = 7'd12;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] abort_ms;
		logic [CFG_W-1:0] digit_gap_ms;
		logic [CFG_W-1:0] interdigit_ms;
		logic [EXT_W-1:0] line1_extension;
		logic [EXT_W-1:0] line2_extension;
	} cfg_t;

	typedef struct packed {
		logic                raw_hook;
		logic                stable_hook;
		logic [PULSE_W-1:0]  pulse_cnt;
		logic [DIAL_W-1:0]   dialed_value;
		logic [DIGITS_W-1:0] digits_taken;
	} line_t;

	function automatic logic [DIGIT_W-1:0] pulse_digit(input logic [PULSE_W-1:0] cnt);
		logic [PULSE_W-1:0] r;
		if (cnt >= 5'd30) begin
			r = cnt - 5'd30;
		end else if (cnt >= 5'd20) begin
			r = cnt - 5'd20;
		end else if (cnt >= 5'd10) begin
			r = cnt - 5'd10;
		end else begin
			r = cnt;
		end
		return r[DIGIT_W-1:0];
	endfunction

	function automatic logic [TONE_W-1:0] tone_of(input logic [STATE_W-1:0] st);
		logic [TONE_W-1:0] t;
		unique case (st)
			ST_DIALTONE: t = TONE_DIAL;
			ST_RINGOUT:  t = TONE_RINGBACK;
			ST_BUSY:     t = TONE_BUSY;
			default:     t = TONE_SILENT;
		endcase
		return t;
	endfunction

endpackage

@@ rtl/core/tlpd_cfg.sv @@
// ----------------------------------------------------------------------------
// tlpd_cfg
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module tlpd_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tlpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlpd_pkg::CFG_W-1:0]     cfg_data,
	output tlpd_pkg::cfg_t                 cfg
);
	import tlpd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= RST_DEBOUNCE;
			cfg_q.abort_ms        <= RST_ABORT;
			cfg_q.digit_gap_ms    <= RST_GAP;
			cfg_q.interdigit_ms   <= RST_INTERDIG;
			cfg_q.line1_extension <= RST_EXT1;
			cfg_q.line2_extension <= RST_EXT2;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_ms     <= cfg_data;
				REG_ABORT:    cfg_q.abort_ms        <= cfg_data;
				REG_GAP:      cfg_q.digit_gap_ms    <= cfg_data;
				REG_INTERDIG: cfg_q.interdigit_ms   <= cfg_data;
				REG_EXT1:     cfg_q.line1_extension <= cfg_data[EXT_W-1:0];
				REG_EXT2:     cfg_q.line2_extension <= cfg_data[EXT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/tlpd_unit.sv @@
// ----------------------------------------------------------------------------
// tlpd_unit
// One line's tick: hook debounce, pulse counting, digit close, abort,
// routing and the call state changes that the line causes on both ends.
// ----------------------------------------------------------------------------
module tlpd_unit #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                         level,
	input  tlpd_pkg::line_t              line,
	input  logic [TIMER_WIDTH-1:0]       deb_timer,
	input  logic [TIMER_WIDTH-1:0]       pulse_timer,
	input  logic [tlpd_pkg::STATE_W-1:0] own_state,
	input  logic [tlpd_pkg::STATE_W-1:0] peer_state,
	input  tlpd_pkg::cfg_t               cfg,
	input  logic [tlpd_pkg::EXT_W-1:0]   own_ext,
	input  logic [tlpd_pkg::EXT_W-1:0]   peer_ext,
	input  logic                         peer_first,
	output tlpd_pkg::line_t              line_nxt,
	output logic [TIMER_WIDTH-1:0]       deb_timer_nxt,
	output logic [TIMER_WIDTH-1:0]       pulse_timer_nxt,
	output logic [tlpd_pkg::STATE_W-1:0] own_state_nxt,
	output logic [tlpd_pkg::STATE_W-1:0] peer_state_nxt,
	output logic                         connect,
	output logic                         release_pair,
	output logic [tlpd_pkg::DIGIT_W-1:0] digit
);
	import tlpd_pkg::*;

	localparam int CW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
	localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

	logic [TIMER_WIDTH-1:0] dbt;
	logic [TIMER_WIDTH-1:0] pt;
	logic [STATE_W-1:0]     cm;
	logic [STATE_W-1:0]     cp;
	logic [DIGIT_W-1:0]     dig;
	logic                   do_route;
	logic                   to_peer;
	line_t                  ln;

	always_comb begin
		ln       = line;
		cm       = own_state;
		cp       = peer_state;
		dig      = NO_DIGIT;
		do_route = 1'b0;
		to_peer  = 1'b0;
		connect  = 1'b0;
		release_pair = 1'b0;

		pt = (pulse_timer == TMAX) ? pulse_timer : pulse_timer + TIMER_WIDTH'(1);
		if (level != line.raw_hook) begin
			ln.raw_hook = level;
			dbt = '0;
		end else begin
			dbt = (deb_timer == TMAX) ? deb_timer : deb_timer + TIMER_WIDTH'(1);
		end

		// Debounced hook edge.
		if ((CW'(dbt) > CW'(cfg.debounce_ms)) && (level != line.stable_hook)) begin
			ln.stable_hook = level;
			if (!level) begin
				if (cm == ST_DIALTONE) begin
					cm              = ST_PULSING;
					ln.pulse_cnt    = PULSE_W'(1);
					ln.dialed_value = '0;
					ln.digits_taken = '0;
					pt              = '0;
				end else if (cm == ST_PULSING) begin
					if (ln.pulse_cnt != PULSE_MAX) begin
						ln.pulse_cnt = ln.pulse_cnt + PULSE_W'(1);
					end
					pt = '0;
				end else begin
					if (cm == ST_RINGOUT && cp == ST_RINGIN) begin
						cp = ST_IDLE;
					end else if (cm == ST_TALKING && cp == ST_TALKING) begin
						cp           = ST_BUSY;
						release_pair = 1'b1;
					end
					cm = ST_IDLE;
				end
			end else begin
				if (cm == ST_IDLE) begin
					cm = ST_DIALTONE;
				end else if (cm == ST_PULSING) begin
					pt = '0;
				end else if (cm == ST_RINGIN) begin
					cm = ST_TALKING;
					if (cp == ST_RINGOUT) begin
						cp      = ST_TALKING;
						connect = 1'b1;
					end
				end
			end
		end

		// Timeouts while dialing. A hang-up here always starts from dialing,
		// so the far end is never touched.
		if (cm == ST_PULSING) begin
			if (!ln.stable_hook) begin
				if (CW'(pt) > CW'(cfg.abort_ms)) begin
					cm = ST_IDLE;
				end
			end else if (ln.pulse_cnt != '0 && CW'(pt) > CW'(cfg.digit_gap_ms)) begin
				dig = pulse_digit(ln.pulse_cnt);
				ln.dialed_value = (ln.dialed_value << 3) + (ln.dialed_value << 1)
					+ DIAL_W'(dig);
				ln.digits_taken = ln.digits_taken + DIGITS_W'(1);
				ln.pulse_cnt    = '0;
				pt              = '0;
				do_route        = (ln.digits_taken >= DIGITS_W'(2));
			end else if (ln.pulse_cnt == '0 && ln.digits_taken != '0
				&& CW'(pt) > CW'(cfg.interdigit_ms)) begin
				do_route = 1'b1;
			end
		end

		// Line one wins when both extensions are equal.
		if (do_route) begin
			to_peer = (ln.dialed_value == peer_ext)
				&& (peer_first || ln.dialed_value != own_ext);
			if (to_peer && cp == ST_IDLE) begin
				cm = ST_RINGOUT;
				cp = ST_RINGIN;
			end else begin
				cm = ST_BUSY;
			end
		end
	end

	assign line_nxt        = ln;
	assign deb_timer_nxt   = dbt;
	assign pulse_timer_nxt = pt;
	assign own_state_nxt   = cm;
	assign peer_state_nxt  = cp;
	assign digit           = dig;

endmodule

@@ rtl/core/two_line_pulse_dial_call_controller_top.sv @@
// ----------------------------------------------------------------------------
// two_line_pulse_dial_call_controller_top
// Two-line pulse-dial call controller driven by one hook sample beat per tick.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick carrying the raw hook levels of
// both lines. The block takes one beat per clock and presents its result
// beat in the next cycle from an output register; a new beat is accepted
// whenever the output register is empty or being emptied in the same cycle.
// Line one is processed before line two within the same cycle, so a change
// that line one makes to line two is seen by line two on that tick. The
// configuration registers are written through a plain indexed write port and
// should only be changed while no result is pending.
module two_line_pulse_dial_call_controller_top #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           hook_line1,
	input  logic                           hook_line2,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tlpd_pkg::TONE_W-1:0]    line1_tone,
	output logic                           line1_ring,
	output logic [tlpd_pkg::TONE_W-1:0]    line2_tone,
	output logic                           line2_ring,
	output logic [tlpd_pkg::CMD_W-1:0]     switch_cmd,
	output logic [tlpd_pkg::STATE_W-1:0]   line1_state,
	output logic [tlpd_pkg::STATE_W-1:0]   line2_state,
	output logic [tlpd_pkg::DIGIT_W-1:0]   line1_digit,
	output logic [tlpd_pkg::DIGIT_W-1:0]   line2_digit,
	input  logic                           cfg_wr_en,
	input  logic [tlpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tlpd_pkg::CFG_W-1:0]     cfg_data
);
	import tlpd_pkg::*;

	cfg_t cfg;

	line_t                  line_q   [2];
	logic [TIMER_WIDTH-1:0] dbt_q    [2];
	logic [TIMER_WIDTH-1:0] pt_q     [2];
	logic [STATE_W-1:0]     state_q  [2];

	line_t                  line_n   [2];
	logic [TIMER_WIDTH-1:0] dbt_n    [2];
	logic [TIMER_WIDTH-1:0] pt_n     [2];

	logic [STATE_W-1:0] l1_own_n;
	logic [STATE_W-1:0] l1_peer_n;
	logic [STATE_W-1:0] l2_own_n;
	logic [STATE_W-1:0] l2_peer_n;
	logic               l1_con;
	logic               l1_rel;
	logic               l2_con;
	logic               l2_rel;
	logic [DIGIT_W-1:0] l1_dig;
	logic [DIGIT_W-1:0] l2_dig;
	logic [STATE_W-1:0] st1_fin;
	logic [STATE_W-1:0] st2_fin;
	logic               accept;

	logic               out_valid_q;
	logic [TONE_W-1:0]  line1_tone_q;
	logic               line1_ring_q;
	logic [TONE_W-1:0]  line2_tone_q;
	logic               line2_ring_q;
	logic [CMD_W-1:0]   switch_cmd_q;
	logic [STATE_W-1:0] line1_state_q;
	logic [STATE_W-1:0] line2_state_q;
	logic [DIGIT_W-1:0] line1_digit_q;
	logic [DIGIT_W-1:0] line2_digit_q;

	tlpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tlpd_unit #(.TIMER_WIDTH(TIMER_WIDTH)) u_line1 (
		.level           (hook_line1),
		.line            (line_q[0]),
		.deb_timer       (dbt_q[0]),
		.pulse_timer     (pt_q[0]),
		.own_state       (state_q[0]),
		.peer_state      (state_q[1]),
		.cfg             (cfg),
		.own_ext         (cfg.line1_extension),
		.peer_ext        (cfg.line2_extension),
		.peer_first      (1'b0),
		.line_nxt        (line_n[0]),
		.deb_timer_nxt   (dbt_n[0]),
		.pulse_timer_nxt (pt_n[0]),
		.own_state_nxt   (l1_own_n),
		.peer_state_nxt  (l1_peer_n),
		.connect         (l1_con),
		.release_pair    (l1_rel),
		.digit           (l1_dig)
	);

	tlpd_unit #(.TIMER_WIDTH(TIMER_WIDTH)) u_line2 (
		.level           (hook_line2),
		.line            (line_q[1]),
		.deb_timer       (dbt_q[1]),
		.pulse_timer     (pt_q[1]),
		.own_state       (l1_peer_n),
		.peer_state      (l1_own_n),
		.cfg             (cfg),
		.own_ext         (cfg.line2_extension),
		.peer_ext        (cfg.line1_extension),
		.peer_first      (1'b1),
		.line_nxt        (line_n[1]),
		.deb_timer_nxt   (dbt_n[1]),
		.pulse_timer_nxt (pt_n[1]),
		.own_state_nxt   (l2_own_n),
		.peer_state_nxt  (l2_peer_n),
		.connect         (l2_con),
		.release_pair    (l2_rel),
		.digit           (l2_dig)
	);

	assign st1_fin  = l2_peer_n;
	assign st2_fin  = l2_own_n;
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				line_q[i]  <= '0;
				dbt_q[i]   <= '0;
				pt_q[i]    <= '0;
				state_q[i] <= ST_IDLE;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				line_q[0]  <= line_n[0];
				line_q[1]  <= line_n[1];
				dbt_q[0]   <= dbt_n[0];
				dbt_q[1]   <= dbt_n[1];
				pt_q[0]    <= pt_n[0];
				pt_q[1]    <= pt_n[1];
				state_q[0] <= st1_fin;
				state_q[1] <= st2_fin;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line1_tone_q  <= tone_of(st1_fin);
			line1_ring_q  <= (st1_fin == ST_RINGIN);
			line2_tone_q  <= tone_of(st2_fin);
			line2_ring_q  <= (st2_fin == ST_RINGIN);
			switch_cmd_q  <= {l1_rel | l2_rel, l1_con | l2_con};
			line1_state_q <= st1_fin;
			line2_state_q <= st2_fin;
			line1_digit_q <= l1_dig;
			line2_digit_q <= l2_dig;
		end
	end

	assign out_valid   = out_valid_q;
	assign line1_tone  = line1_tone_q;
	assign line1_ring  = line1_ring_q;
	assign line2_tone  = line2_tone_q;
	assign line2_ring  = line2_ring_q;
	assign switch_cmd  = switch_cmd_q;
	assign line1_state = line1_state_q;
	assign line2_state = line2_state_q;
	assign line1_digit = line1_digit_q;
	assign line2_digit = line2_digit_q;

endmodule

@@ tb/sv/two_line_pulse_dial_call_controller_top_tb.sv @@
// ----------------------------------------------------------------------------
// two_line_pulse_dial_call_controller_top_tb
// Self-checking bench for the two-line pulse-dial call controller.
// ----------------------------------------------------------------------------
// Hook samples are queued as whole call scenarios: dialing by pulse trains,
// routing to the other line, answer, hang-up, busy and abort. The sender and
// the receiver idle at random, and the receiver holds off once for a long
// stretch. Every accepted tick is run through a cycle-exact model of both
// lines, and each result beat is compared field by field. Several register
// settings are used, the extremes among them, each written while idle.
// ----------------------------------------------------------------------------
module two_line_pulse_dial_call_controller_top_tb;
	import tlpd_pkg::*;

	localparam int TMR_W = 16;
	localparam int QUIET_LIMIT = 600;
	localparam int HOLDOFF_CYCLES = 60;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE0 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE1 = 3'd7;

	typedef struct packed {
		logic h1;
		logic h2;
	} hooks_t;

	typedef struct packed {
		logic [TONE_W-1:0]  tone1;
		logic               ring1;
		logic [TONE_W-1:0]  tone2;
		logic               ring2;
		logic [CMD_W-1:0]   cmd;
		logic [STATE_W-1:0] st1;
		logic [STATE_W-1:0] st2;
		logic [DIGIT_W-1:0] dig1;
		logic [DIGIT_W-1:0] dig2;
	} tick_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic hook_line1 = 1'b0;
	logic hook_line2 = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [TONE_W-1:0] line1_tone;
	logic line1_ring;
	logic [TONE_W-1:0] line2_tone;
	logic line2_ring;
	logic [CMD_W-1:0] switch_cmd;
	logic [STATE_W-1:0] line1_state;
	logic [STATE_W-1:0] line2_state;
	logic [DIGIT_W-1:0] line1_digit;
	logic [DIGIT_W-1:0] line2_digit;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	two_line_pulse_dial_call_controller_top #(
		.TIMER_WIDTH(TMR_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.hook_line1(hook_line1),
		.hook_line2(hook_line2),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.line1_tone(line1_tone),
		.line1_ring(line1_ring),
		.line2_tone(line2_tone),
		.line2_ring(line2_ring),
		.switch_cmd(switch_cmd),
		.line1_state(line1_state),
		.line2_state(line2_state),
		.line1_digit(line1_digit),
		.line2_digit(line2_digit),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	hooks_t hook_samples_q[$];
	tick_out_t tick_results_due[$];
	logic line_a[$];
	logic line_b[$];
	int mismatches = 0;
	int beats_checked = 0;
	int quiet_cycles = 0;
	int holdoff_left = 0;
	bit holdoff_done = 1'b0;
	bit no_gaps = 1'b0;
	int settle_w, gap_w, abort_w, idgt_w;

	// Model of both lines.
	cfg_t dial_cfg;
	logic [STATE_W-1:0] call_st [2];
	logic raw_lvl [2];
	logic stable_lvl [2];
	logic [TMR_W-1:0] settle_tmr [2];
	logic [TMR_W-1:0] pulse_tmr [2];
	logic [PULSE_W-1:0] pulses [2];
	logic [DIAL_W-1:0] dialed [2];
	logic [DIGITS_W-1:0] ndigits [2];
	logic [CMD_W-1:0] pair_cmd;

	function automatic logic [TMR_W-1:0] bump(logic [TMR_W-1:0] t);
		return (t == '1) ? t : t + 1'b1;
	endfunction

	function automatic logic [TONE_W-1:0] line_tone(logic [STATE_W-1:0] st);
		case (st)
			ST_DIALTONE: return TONE_DIAL;
			ST_RINGOUT: return TONE_RINGBACK;
			ST_BUSY: return TONE_BUSY;
			default: return TONE_SILENT;
		endcase
	endfunction

	function automatic void release_line(int me);
		int peer;
		peer = 1 - me;
		if (call_st[me] == ST_RINGOUT && call_st[peer] == ST_RINGIN) begin
			call_st[peer] = ST_IDLE;
		end else if (call_st[me] == ST_TALKING && call_st[peer] == ST_TALKING) begin
			call_st[peer] = ST_BUSY;
			pair_cmd[1] = 1'b1;
		end
		call_st[me] = ST_IDLE;
	endfunction

	function automatic void place_call(int me);
		int tgt;
		tgt = 2;
		if (dialed[me] == dial_cfg.line1_extension) begin
			tgt = 0;
		end else if (dialed[me] == dial_cfg.line2_extension) begin
			tgt = 1;
		end
		if (tgt == 2 || tgt == me) begin
			call_st[me] = ST_BUSY;
		end else if (call_st[tgt] == ST_IDLE) begin
			call_st[me] = ST_RINGOUT;
			call_st[tgt] = ST_RINGIN;
		end else begin
			call_st[me] = ST_BUSY;
		end
	endfunction

	function automatic void settle_edge(int me, logic off);
		int peer;
		peer = 1 - me;
		if (!off) begin
			if (call_st[me] == ST_DIALTONE) begin
				call_st[me] = ST_PULSING;
				pulses[me] = PULSE_W'(1);
				dialed[me] = '0;
				ndigits[me] = '0;
				pulse_tmr[me] = '0;
			end else if (call_st[me] == ST_PULSING) begin
				if (pulses[me] != PULSE_MAX) begin
					pulses[me] = pulses[me] + 1'b1;
				end
				pulse_tmr[me] = '0;
			end else begin
				release_line(me);
			end
		end else begin
			if (call_st[me] == ST_IDLE) begin
				call_st[me] = ST_DIALTONE;
			end else if (call_st[me] == ST_PULSING) begin
				pulse_tmr[me] = '0;
			end else if (call_st[me] == ST_RINGIN) begin
				call_st[me] = ST_TALKING;
				if (call_st[peer] == ST_RINGOUT) begin
					call_st[peer] = ST_TALKING;
					pair_cmd[0] = 1'b1;
				end
			end
		end
	endfunction

	function automatic logic [DIGIT_W-1:0] dial_timers(int me);
		logic [DIGIT_W-1:0] dg;
		dg = NO_DIGIT;
		if (call_st[me] == ST_PULSING) begin
			if (!stable_lvl[me]) begin
				if (pulse_tmr[me] > dial_cfg.abort_ms) begin
					release_line(me);
				end
			end else if (pulses[me] != 0 && pulse_tmr[me] > dial_cfg.digit_gap_ms) begin
				dg = (pulses[me] == 10) ? 4'd0 : DIGIT_W'(pulses[me] % 10);
				dialed[me] = DIAL_W'(int'(dialed[me]) * 10 + int'(dg));
				ndigits[me] = ndigits[me] + 1'b1;
				pulses[me] = '0;
				pulse_tmr[me] = '0;
				if (ndigits[me] >= 2) begin
					place_call(me);
				end
			end else if (pulses[me] == 0 && ndigits[me] != 0 &&
					pulse_tmr[me] > dial_cfg.interdigit_ms) begin
				place_call(me);
			end
		end
		return dg;
	endfunction

	function automatic tick_out_t exchange_tick(logic h1, logic h2);
		tick_out_t r;
		logic lvl;
		logic [DIGIT_W-1:0] dg [2];
		int i;
		pair_cmd = '0;
		for (i = 0; i < 2; i++) begin
			lvl = (i == 0) ? h1 : h2;
			settle_tmr[i] = bump(settle_tmr[i]);
			pulse_tmr[i] = bump(pulse_tmr[i]);
			if (lvl != raw_lvl[i]) begin
				raw_lvl[i] = lvl;
				settle_tmr[i] = '0;
			end
			if (settle_tmr[i] > dial_cfg.debounce_ms && lvl != stable_lvl[i]) begin
				stable_lvl[i] = lvl;
				settle_edge(i, lvl);
			end
			dg[i] = dial_timers(i);
		end
		r.tone1 = line_tone(call_st[0]);
		r.ring1 = (call_st[0] == ST_RINGIN);
		r.tone2 = line_tone(call_st[1]);
		r.ring2 = (call_st[1] == ST_RINGIN);
		r.cmd = pair_cmd;
		r.st1 = call_st[0];
		r.st2 = call_st[1];
		r.dig1 = dg[0];
		r.dig2 = dg[1];
		return r;
	endfunction

	task automatic report_mismatch(string what, integer got, integer want);
		mismatches++;
		if (mismatches <= 40) begin
			$display("mismatch at beat %0d: %s got %0d expected %0d",
				beats_checked, what, got, want);
		end
	endtask

	task automatic compare_tick(tick_out_t got, tick_out_t want);
		if (got.tone1 !== want.tone1) report_mismatch("line1_tone", got.tone1, want.tone1);
		if (got.ring1 !== want.ring1) report_mismatch("line1_ring", got.ring1, want.ring1);
		if (got.tone2 !== want.tone2) report_mismatch("line2_tone", got.tone2, want.tone2);
		if (got.ring2 !== want.ring2) report_mismatch("line2_ring", got.ring2, want.ring2);
		if (got.cmd !== want.cmd) report_mismatch("switch_cmd", got.cmd, want.cmd);
		if (got.st1 !== want.st1) report_mismatch("line1_state", got.st1, want.st1);
		if (got.st2 !== want.st2) report_mismatch("line2_state", got.st2, want.st2);
		if (got.dig1 !== want.dig1) report_mismatch("line1_digit", got.dig1, want.dig1);
		if (got.dig2 !== want.dig2) report_mismatch("line2_digit", got.dig2, want.dig2);
	endtask

	// Sender: offers queued hook samples and predicts each accepted tick.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			hook_line1 <= 1'b0;
			hook_line2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				tick_results_due.push_back(exchange_tick(hook_line1, hook_line2));
			end
			if (!in_valid || in_ready) begin
				if (hook_samples_q.size() != 0 &&
						(no_gaps || $urandom_range(0, 99) >= 27)) begin
					hooks_t s;
					s = hook_samples_q.pop_front();
					in_valid <= 1'b1;
					hook_line1 <= s.h1;
					hook_line2 <= s.h2;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result beat and throttles out_ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (tick_results_due.size() == 0) begin
					report_mismatch("result beat with nothing expected", 0, 0);
				end else begin
					compare_tick({line1_tone, line1_ring, line2_tone, line2_ring, switch_cmd,
						line1_state, line2_state, line1_digit, line2_digit},
						tick_results_due.pop_front());
				end
				beats_checked++;
			end
			if (holdoff_left != 0) begin
				holdoff_left <= holdoff_left - 1;
				out_ready <= 1'b0;
			end else if (!holdoff_done && beats_checked >= 100) begin
				holdoff_done <= 1'b1;
				holdoff_left <= HOLDOFF_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_gaps || ($urandom_range(0, 99) >= 27);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function automatic int clip(int v, int cap);
		return (v > cap) ? cap : v;
	endfunction

	task automatic hold_level(bit side, logic lvl, int n);
		repeat (n) begin
			if (side) begin
				line_b.push_back(lvl);
			end else begin
				line_a.push_back(lvl);
			end
		end
	endtask

	task automatic dial_digit(int dig);
		int n, r;
		n = (dig == 0) ? 10 : dig;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			n = $urandom_range(28, 34);
		end else if (r < 12) begin
			n = $urandom_range(11, 27);
		end
		repeat (n) begin
			hold_level(0, 1'b0, settle_w + $urandom_range(0, 1));
			hold_level(0, 1'b1, settle_w + $urandom_range(0, 1));
		end
		hold_level(0, 1'b1, gap_w);
	endtask

	task automatic add_scenario();
		int kind, who, num, talk, i;
		logic [EXT_W-1:0] own_ext, peer_ext;
		hooks_t s;
		line_a.delete();
		line_b.delete();
		settle_w = clip(int'(dial_cfg.debounce_ms), 4) + 2;
		gap_w = clip(int'(dial_cfg.digit_gap_ms), 20) + settle_w + 1;
		abort_w = clip(int'(dial_cfg.abort_ms), 30) + settle_w + 1;
		idgt_w = clip(int'(dial_cfg.interdigit_ms), 30) + settle_w + 1;
		who = $urandom_range(0, 1);
		own_ext = who ? dial_cfg.line2_extension : dial_cfg.line1_extension;
		peer_ext = who ? dial_cfg.line1_extension : dial_cfg.line2_extension;
		kind = $urandom_range(0, 99);
		if (kind >= 94) begin
			repeat ($urandom_range(4, 16)) begin
				line_a.push_back(1'($urandom_range(0, 1)));
				line_b.push_back(1'($urandom_range(0, 1)));
			end
		end else if (kind >= 88) begin
			hold_level(0, 1'b1, settle_w + $urandom_range(0, 3));
			repeat ($urandom_range(1, 2)) begin
				hold_level(0, 1'b0, settle_w + $urandom_range(0, 1));
				hold_level(0, 1'b1, settle_w + $urandom_range(0, 1));
			end
			hold_level(0, 1'b0, abort_w);
		end else begin
			hold_level(0, 1'b1, settle_w + $urandom_range(0, 3));
			if (kind >= 60 && kind < 70) begin
				num = $urandom_range(0, 1) ? int'(own_ext) : $urandom_range(0, 99);
			end else begin
				num = int'(peer_ext);
			end
			if (kind >= 80) begin
				dial_digit($urandom_range(0, 9));
				hold_level(0, 1'b1, idgt_w);
			end else begin
				dial_digit(num / 10);
				dial_digit(num % 10);
			end
			talk = $urandom_range(5, 40);
			if (kind >= 70 && kind < 80) begin
				hold_level(1, 1'b1, line_a.size() + talk);
			end else begin
				hold_level(1, 1'b0, line_a.size() + $urandom_range(0, 8));
				if ($urandom_range(0, 99) < 70) begin
					hold_level(1, 1'b1, $urandom_range(settle_w, 30));
				end
			end
			hold_level(0, 1'b1, talk);
		end
		while (line_a.size() < line_b.size()) line_a.push_back(1'b0);
		while (line_b.size() < line_a.size()) line_b.push_back(1'b0);
		i = settle_w + $urandom_range(1, 4);
		hold_level(0, 1'b0, i);
		hold_level(1, 1'b0, i);
		for (i = 0; i < line_a.size(); i++) begin
			s.h1 = who ? line_b[i] : line_a[i];
			s.h2 = who ? line_a[i] : line_b[i];
			hook_samples_q.push_back(s);
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_DEBOUNCE: dial_cfg.debounce_ms = val;
			REG_ABORT: dial_cfg.abort_ms = val;
			REG_GAP: dial_cfg.digit_gap_ms = val;
			REG_INTERDIG: dial_cfg.interdigit_ms = val;
			REG_EXT1: dial_cfg.line1_extension = val[EXT_W-1:0];
			REG_EXT2: dial_cfg.line2_extension = val[EXT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Sampled at the falling edge, when the clocked processes have settled.
	task automatic wait_drained();
		@(negedge clk);
		while (hook_samples_q.size() != 0 || in_valid || tick_results_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_setting(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] abrt,
			logic [CFG_W-1:0] gap, logic [CFG_W-1:0] idg, logic [CFG_W-1:0] e1,
			logic [CFG_W-1:0] e2, int budget);
		int start;
		wait_drained();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_ABORT, abrt);
		write_reg(REG_GAP, gap);
		write_reg(REG_INTERDIG, idg);
		write_reg(REG_EXT1, e1);
		write_reg(REG_EXT2, e2);
		start = hook_samples_q.size();
		while (hook_samples_q.size() - start < budget) add_scenario();
	endtask

	initial begin
		int i;
		hooks_t s;
		dial_cfg.debounce_ms = RST_DEBOUNCE;
		dial_cfg.abort_ms = RST_ABORT;
		dial_cfg.digit_gap_ms = RST_GAP;
		dial_cfg.interdigit_ms = RST_INTERDIG;
		dial_cfg.line1_extension = RST_EXT1;
		dial_cfg.line2_extension = RST_EXT2;
		for (i = 0; i < 2; i++) begin
			call_st[i] = ST_IDLE;
			raw_lvl[i] = 1'b0;
			stable_lvl[i] = 1'b0;
			settle_tmr[i] = '0;
			pulse_tmr[i] = '0;
			pulses[i] = '0;
			dialed[i] = '0;
			ndigits[i] = '0;
		end
		pair_cmd = '0;

		// Reset settings: both lines go off-hook long enough to settle, then
		// short glitches of every hook combination.
		s.h1 = 1'b1;
		s.h2 = 1'b1;
		repeat (17) hook_samples_q.push_back(s);
		s.h1 = 1'b0;
		s.h2 = 1'b1;
		hook_samples_q.push_back(s);
		s.h1 = 1'b1;
		s.h2 = 1'b0;
		hook_samples_q.push_back(s);
		s.h1 = 1'b0;
		s.h2 = 1'b0;
		hook_samples_q.push_back(s);
		s.h1 = 1'b1;
		s.h2 = 1'b1;
		hook_samples_q.push_back(s);
		repeat (40) begin
			s.h1 = 1'($urandom_range(0, 1));
			s.h2 = 1'($urandom_range(0, 1));
			hook_samples_q.push_back(s);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		run_setting(16'd0, 16'd6, 16'd4, 16'd8, 16'd11, 16'd12, 50);
		wait_drained();
		no_gaps = 1'b1;
		run_setting(16'd1, 16'd8, 16'd5, 16'd10, 16'd21, 16'd12, 50);
		wait_drained();
		no_gaps = 1'b0;
		run_setting(16'd2, 16'd10, 16'd6, 16'd12, 16'd0, 16'd99, 40);
		run_setting(16'd1, 16'd8, 16'd5, 16'd10, 16'd13, 16'd13, 30);
		run_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd99, 16'd0, 20);
		run_setting(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFF8B, 16'hFF8C, 20);
		run_setting(16'hFFFF, 16'd5, 16'd4, 16'd8, 16'd11, 16'd12, 15);
		wait_drained();
		write_reg(REG_SPARE0, 16'hFFFF);
		write_reg(REG_SPARE1, 16'h0000);
		run_setting(16'd1, 16'd7, 16'd4, 16'd9, 16'd11, 16'd12, 35);

		wait_drained();
		repeat (5) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
